FILE: design/qpa_pkg.sv
// Package: transaction types, constants and helpers for the quadrilateral core.
`timescale 1ns / 1ps
package qpa_pkg;

    localparam int QPA_COORD_BITS = 16;
    localparam int QPA_SIDE_BITS  = QPA_COORD_BITS - 2;
    localparam int QPA_PERIM_BITS = 23;
    localparam int QPA_AREA_BITS  = 33;
    localparam int QPA_RAD_BITS   = 64;
    localparam int QPA_ROOT_BITS  = QPA_RAD_BITS / 2;
    localparam int QPA_SQRT_STEPS = QPA_RAD_BITS / 2;

    typedef struct packed {
        logic                             func;
        logic signed [QPA_COORD_BITS-1:0] first_x;
        logic signed [QPA_COORD_BITS-1:0] first_y;
        logic signed [QPA_COORD_BITS-1:0] second_x;
        logic signed [QPA_COORD_BITS-1:0] second_y;
        logic signed [QPA_COORD_BITS-1:0] third_x;
        logic signed [QPA_COORD_BITS-1:0] third_y;
        logic signed [QPA_COORD_BITS-1:0] fourth_x;
        logic signed [QPA_COORD_BITS-1:0] fourth_y;
    } t_qpa_in;

    typedef struct packed {
        logic [QPA_PERIM_BITS-1:0] perimeter_out;
        logic [QPA_AREA_BITS-1:0]  area_out;
        logic                      invalid;
    } t_qpa_out;

    // side information that rides along with the square root pipeline
    typedef struct packed {
        logic                      func;
        logic                      bad;
        logic                      use_root;
        logic [QPA_PERIM_BITS-1:0] perim;
        logic [QPA_AREA_BITS-1:0]  area;
    } t_qpa_info;

    typedef struct packed {
        logic [3:0][QPA_RAD_BITS-1:0] rad;
        t_qpa_info                    info;
    } t_qpa_prep;

    function automatic logic [QPA_COORD_BITS-1:0] qpa_absdiff(
        input logic signed [QPA_COORD_BITS-1:0] a,
        input logic signed [QPA_COORD_BITS-1:0] b
    );
        logic signed [QPA_COORD_BITS:0] d;
        d = $signed({b[QPA_COORD_BITS-1], b}) - $signed({a[QPA_COORD_BITS-1], a});
        if (d[QPA_COORD_BITS]) begin
            d = -d;
        end
        return d[QPA_COORD_BITS-1:0];
    endfunction

endpackage

FILE: design/qpa_isqrt.sv
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module qpa_isqrt
    import qpa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [QPA_RAD_BITS-1:0]  i_rad,
    output logic [QPA_ROOT_BITS-1:0] o_root
);

    logic [QPA_RAD_BITS-1:0] r_num  [QPA_SQRT_STEPS];
    logic [QPA_RAD_BITS-1:0] r_root [QPA_SQRT_STEPS];
    logic [QPA_RAD_BITS-1:0] n_num  [QPA_SQRT_STEPS];
    logic [QPA_RAD_BITS-1:0] n_root [QPA_SQRT_STEPS];

    always_comb begin
        logic [QPA_RAD_BITS-1:0] num;
        logic [QPA_RAD_BITS-1:0] root;
        logic [QPA_RAD_BITS-1:0] bitv;
        logic [QPA_RAD_BITS-1:0] trial;
        for (int k = 0; k < QPA_SQRT_STEPS; k++) begin
            num  = (k == 0) ? i_rad : r_num[(k == 0) ? 0 : k - 1];
            root = (k == 0) ? '0    : r_root[(k == 0) ? 0 : k - 1];
            bitv = QPA_RAD_BITS'(1) << (QPA_RAD_BITS - 2 - 2 * k);
            trial = root + bitv;
            if (num >= trial) begin
                n_num[k]  = num - trial;
                n_root[k] = (root >> 1) + bitv;
            end else begin
                n_num[k]  = num;
                n_root[k] = root >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < QPA_SQRT_STEPS; k++) begin
                r_num[k]  <= n_num[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[QPA_SQRT_STEPS-1][QPA_ROOT_BITS-1:0];

endmodule

FILE: design/qpa_front.sv
// Front stages: differences, products and sums that form the square root operands.
`timescale 1ns / 1ps
module qpa_front
    import qpa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_valid,
    input  t_qpa_in   i_item,
    output logic      o_valid,
    output t_qpa_prep o_prep
);

    localparam int CB = QPA_COORD_BITS;
    localparam int SB = QPA_SIDE_BITS;

    logic signed [CB-1:0] v [8];

    // stage A
    logic                 r_a_valid, r_a_func, r_a_ok;
    logic [CB-1:0]        r_a_dx [4];
    logic [CB-1:0]        r_a_dy [4];
    logic signed [2*CB-1:0] r_a_pp [4];
    logic signed [2*CB-1:0] r_a_pm [4];
    logic [SB+2:0]        r_a_sum;
    logic [SB-1:0]        r_a_side [4];
    // stage B
    logic                 r_b_valid, r_b_func, r_b_ok, r_b_neg, r_b_zero;
    logic [2*CB-1:0]      r_b_sqx [4];
    logic [2*CB-1:0]      r_b_sqy [4];
    logic signed [2*CB:0] r_b_d [4];
    logic [SB+2:0]        r_b_sum;
    logic [CB-1:0]        r_b_tmag [4];
    // stage C
    logic                 r_c_valid, r_c_func, r_c_ok, r_c_neg, r_c_zero;
    logic [2*CB:0]        r_c_esq [4];
    logic signed [2*CB+2:0] r_c_s;
    logic [SB+2:0]        r_c_sum;
    logic [2*CB-1:0]      r_c_p01, r_c_p23;
    // stage D
    logic                 r_d_valid;
    t_qpa_prep            r_d_prep;

    logic signed [SB+3:0] t [4];
    logic [SB+2:0]        a_sum;
    logic [QPA_RAD_BITS-1:0] prod;
    logic [2*CB+2:0]      s_mag;
    t_qpa_prep            n_d_prep;

    assign v[0] = i_item.first_x;
    assign v[1] = i_item.first_y;
    assign v[2] = i_item.second_x;
    assign v[3] = i_item.second_y;
    assign v[4] = i_item.third_x;
    assign v[5] = i_item.third_y;
    assign v[6] = i_item.fourth_x;
    assign v[7] = i_item.fourth_y;

    assign a_sum = (SB+3)'(v[0][SB-1:0]) + (SB+3)'(v[1][SB-1:0])
                 + (SB+3)'(v[2][SB-1:0]) + (SB+3)'(v[3][SB-1:0]);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            t[i] = $signed({1'b0, r_a_sum}) - $signed({2'b00, r_a_side[i], 1'b0});
        end
    end

    assign prod  = QPA_RAD_BITS'(r_c_p01) * QPA_RAD_BITS'(r_c_p23);
    assign s_mag = r_c_s[2*CB+2] ? (2*CB+3)'(-r_c_s) : (2*CB+3)'(r_c_s);

    always_comb begin
        n_d_prep = '0;
        n_d_prep.info.func = r_c_func;
        if (r_c_func) begin
            for (int k = 0; k < 4; k++) begin
                n_d_prep.rad[k] = QPA_RAD_BITS'({r_c_esq[k], 8'b0});
            end
            n_d_prep.info.area = s_mag[QPA_AREA_BITS:1];
        end else begin
            n_d_prep.rad[0] = prod >> 4;
            n_d_prep.info.bad      = !r_c_ok || (!r_c_zero && r_c_neg);
            n_d_prep.info.use_root = r_c_ok && !r_c_zero && !r_c_neg;
            if (r_c_ok) begin
                n_d_prep.info.perim = QPA_PERIM_BITS'({r_c_sum, 4'b0});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage A
            r_a_func <= i_item.func;
            r_a_ok   <= (v[0][CB-1:SB] == '0) && (v[1][CB-1:SB] == '0)
                     && (v[2][CB-1:SB] == '0) && (v[3][CB-1:SB] == '0);
            r_a_sum  <= a_sum;
            for (int k = 0; k < 4; k++) begin
                r_a_dx[k]   <= qpa_absdiff(v[2*k],   v[(2*k+2)%8]);
                r_a_dy[k]   <= qpa_absdiff(v[2*k+1], v[(2*k+3)%8]);
                r_a_side[k] <= v[k][SB-1:0];
                r_a_pp[k]   <= v[2*k] * v[(2*k+3)%8];
                r_a_pm[k]   <= v[2*k+1] * v[(2*k+2)%8];
            end
            // stage B
            r_b_func <= r_a_func;
            r_b_ok   <= r_a_ok;
            r_b_sum  <= r_a_sum;
            r_b_neg  <= t[0][SB+3] ^ t[1][SB+3] ^ t[2][SB+3] ^ t[3][SB+3];
            r_b_zero <= (t[0] == '0) || (t[1] == '0) || (t[2] == '0) || (t[3] == '0);
            for (int k = 0; k < 4; k++) begin
                r_b_sqx[k]  <= r_a_dx[k] * r_a_dx[k];
                r_b_sqy[k]  <= r_a_dy[k] * r_a_dy[k];
                r_b_d[k]    <= (2*CB+1)'(r_a_pp[k]) - (2*CB+1)'(r_a_pm[k]);
                r_b_tmag[k] <= t[k][SB+3] ? CB'(-t[k]) : CB'(t[k]);
            end
            // stage C
            r_c_func <= r_b_func;
            r_c_ok   <= r_b_ok;
            r_c_sum  <= r_b_sum;
            r_c_neg  <= r_b_neg;
            r_c_zero <= r_b_zero;
            r_c_p01  <= r_b_tmag[0] * r_b_tmag[1];
            r_c_p23  <= r_b_tmag[2] * r_b_tmag[3];
            r_c_s    <= (2*CB+3)'(r_b_d[0]) + (2*CB+3)'(r_b_d[1])
                      + (2*CB+3)'(r_b_d[2]) + (2*CB+3)'(r_b_d[3]);
            for (int k = 0; k < 4; k++) begin
                r_c_esq[k] <= (2*CB+1)'(r_b_sqx[k]) + (2*CB+1)'(r_b_sqy[k]);
            end
            // stage D
            r_d_prep <= n_d_prep;
        end
    end

    assign o_valid = r_d_valid;
    assign o_prep  = r_d_prep;

endmodule

FILE: design/quadrilateral_perimeter_area_core.sv
// Top level: quadrilateral perimeter and area, shoelace and Brahmagupta forms.
//
//  channel  direction  payload    handshake
//  input    in         t_qpa_in   i_valid / o_stall
//  output   out        t_qpa_out  o_valid / i_stall
//
// One transaction per cycle sustained while the output is not stalled; the pipeline has four front stages,
// 32 square root stages (one root bit each) and the output register.
// Synchronous active-low reset clears all valid bits; payload is not reset.
// A stall on the output freezes the whole pipeline in place, so o_stall
// follows i_stall only while the output register holds a transaction.
`timescale 1ns / 1ps
module quadrilateral_perimeter_area_core
    import qpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_qpa_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_qpa_out o_data
);

    logic                     en;
    logic                     front_valid;
    t_qpa_prep                front_prep;
    logic [QPA_ROOT_BITS-1:0] root [4];

    logic                     r_dly_valid [QPA_SQRT_STEPS];
    t_qpa_info                r_dly_info  [QPA_SQRT_STEPS];
    logic                     r_out_valid;
    t_qpa_out                 r_out;
    t_qpa_out                 n_out;
    t_qpa_info                tail;

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    qpa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_item  (i_data),
        .o_valid (front_valid),
        .o_prep  (front_prep)
    );

    for (genvar g = 0; g < 4; g++) begin : g_sqrt
        qpa_isqrt u_isqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rad  (front_prep.rad[g]),
            .o_root (root[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QPA_SQRT_STEPS; k++) begin
                r_dly_valid[k] <= 1'b0;
            end
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_dly_valid[0] <= front_valid;
            for (int k = 1; k < QPA_SQRT_STEPS; k++) begin
                r_dly_valid[k] <= r_dly_valid[k-1];
            end
            r_out_valid <= r_dly_valid[QPA_SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly_info[0] <= front_prep.info;
            for (int k = 1; k < QPA_SQRT_STEPS; k++) begin
                r_dly_info[k] <= r_dly_info[k-1];
            end
            r_out <= n_out;
        end
    end

    assign tail = r_dly_info[QPA_SQRT_STEPS-1];

    always_comb begin
        n_out.invalid = tail.bad;
        if (tail.func) begin
            n_out.perimeter_out = QPA_PERIM_BITS'(root[0]) + QPA_PERIM_BITS'(root[1])
                                + QPA_PERIM_BITS'(root[2]) + QPA_PERIM_BITS'(root[3]);
            n_out.area_out      = tail.area;
        end else begin
            n_out.perimeter_out = tail.perim;
            n_out.area_out      = tail.use_root ? QPA_AREA_BITS'(root[0]) : tail.area;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

FILE: tb/tb_quadrilateral_perimeter_area_core.sv
// Testbench: quadrilateral perimeter/area core, checked against a built-in predictor.
`timescale 1ns / 1ps
module tb_quadrilateral_perimeter_area_core;
    import qpa_pkg::*;

    localparam int LATENCY = 37;
    localparam int N_RANDOM = 1600;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_stall;
    t_qpa_in  i_data;
    logic     o_valid;
    logic     i_stall;
    t_qpa_out o_data;

    quadrilateral_perimeter_area_core u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    t_qpa_out shape_results[$];
    int       n_errors;
    bit       tail_phase;
    bit       long_holdoff;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("tb_quadrilateral_perimeter_area_core NOT OK");
        $finish;
    end

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] root;
        logic [63:0] bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [63:0] edge_length(input longint xa, ya, xb, yb);
        longint dx;
        longint dy;
        dx = xb - xa;
        dy = yb - ya;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return root64((dx * dx + dy * dy) << 8);
    endfunction

    function automatic t_qpa_out predict_shape(input t_qpa_in s);
        t_qpa_out r;
        longint   v[8];
        longint   sum;
        longint   t;
        longint   sl;
        logic [63:0] prod;
        logic [63:0] pm;
        int       neg;
        bit       zero;
        bit       ok;
        v[0] = s.first_x;  v[1] = s.first_y;
        v[2] = s.second_x; v[3] = s.second_y;
        v[4] = s.third_x;  v[5] = s.third_y;
        v[6] = s.fourth_x; v[7] = s.fourth_y;
        r = '0;
        if (s.func) begin
            pm = edge_length(v[0], v[1], v[2], v[3]) + edge_length(v[2], v[3], v[4], v[5])
               + edge_length(v[4], v[5], v[6], v[7]) + edge_length(v[6], v[7], v[0], v[1]);
            sl = v[0] * v[3] + v[2] * v[5] + v[4] * v[7] + v[6] * v[1]
               - (v[1] * v[2] + v[3] * v[4] + v[5] * v[6] + v[7] * v[0]);
            if (sl < 0) sl = -sl;
            r.perimeter_out = pm[QPA_PERIM_BITS-1:0];
            r.area_out = QPA_AREA_BITS'(sl >>> 1);
        end else begin
            ok = 1'b1;
            for (int i = 0; i < 4; i++)
                if (v[i] < 0 || v[i] > 16383) ok = 1'b0;
            if (!ok) begin
                r.invalid = 1'b1;
            end else begin
                sum = v[0] + v[1] + v[2] + v[3];
                r.perimeter_out = QPA_PERIM_BITS'(sum << 4);
                prod = 64'd1;
                neg = 0;
                zero = 1'b0;
                for (int i = 0; i < 4; i++) begin
                    t = sum - 2 * v[i];
                    if (t == 0) zero = 1'b1;
                    if (t < 0) begin
                        neg++;
                        t = -t;
                    end
                    prod = prod * 64'(t);
                end
                if (zero) r.area_out = '0;
                else if (neg % 2 != 0) r.invalid = 1'b1;
                else begin
                    pm = root64(prod >> 4);
                    r.area_out = pm[QPA_AREA_BITS-1:0];
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch %s got %0d expected %0d", $time, what, got, want);
        n_errors++;
    endtask

    // receiver: random stall bursts, one long hold-off, free-running at the tail
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_holdoff) begin
                i_stall <= 1'b1;
                repeat (200) @(posedge i_clk);
                long_holdoff = 1'b0;
                i_stall <= 1'b0;
            end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_qpa_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (shape_results.size() == 0) begin
                report_mismatch("unexpected transaction", 0, 0);
            end else begin
                want = shape_results.pop_front();
                if (o_data.perimeter_out !== want.perimeter_out)
                    report_mismatch("perimeter", o_data.perimeter_out, want.perimeter_out);
                if (o_data.area_out !== want.area_out)
                    report_mismatch("area", o_data.area_out, want.area_out);
                if (o_data.invalid !== want.invalid)
                    report_mismatch("invalid", o_data.invalid, want.invalid);
            end
        end
    end

    task automatic send_shape(input t_qpa_in s, input bit gaps);
        int n;
        if (gaps && !tail_phase && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= s;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        shape_results.push_back(predict_shape(s));
    endtask

    function automatic logic signed [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($signed($urandom_range(0, 200)) - 100);
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($signed($urandom_range(0, 4000)) - 2000);
        endcase
    endfunction

    function automatic logic signed [15:0] rand_side();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(0, 65535));
            1: return 16'($urandom_range(16380, 16390));
            default: return 16'($urandom_range(0, 2000));
        endcase
    endfunction

    typedef struct {
        t_qpa_in  shape;
        bit       known;
        t_qpa_out result;
    } t_shape_row;

    t_shape_row shape_table[$];

    function automatic t_qpa_in mk(input bit f, input int a, b, c, d, e, g, h, k);
        t_qpa_in s;
        s.func = f;
        s.first_x = 16'(a);  s.first_y = 16'(b);
        s.second_x = 16'(c); s.second_y = 16'(d);
        s.third_x = 16'(e);  s.third_y = 16'(g);
        s.fourth_x = 16'(h); s.fourth_y = 16'(k);
        return s;
    endfunction

    task automatic add_row(input t_qpa_in s, input bit known, input int p, input longint a,
                           input bit bad);
        t_shape_row row;
        row.shape = s;
        row.known = known;
        row.result.perimeter_out = QPA_PERIM_BITS'(p);
        row.result.area_out = QPA_AREA_BITS'(a);
        row.result.invalid = bad;
        shape_table.push_back(row);
    endtask

    initial begin
        t_qpa_in s;
        n_errors = 0;
        tail_phase = 1'b0;
        long_holdoff = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_rst_n = 1'b0;

        add_row(mk(1, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
        add_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0, 0);
        // negative side rejected
        add_row(mk(0, -1, 5, 5, 5, 0, 0, 0, 0), 1, 0, 0, 1);
        // side above range rejected
        add_row(mk(0, 16384, 5, 5, 5, 0, 0, 0, 0), 1, 0, 0, 1);
        add_row(mk(0, 16383, 16383, 16383, 16383, -1, -1, -1, -1), 0, 0, 0, 0);
        // one side longer than the rest: negative product
        add_row(mk(0, 100, 1, 1, 1, 0, 0, 0, 0), 1, 103 << 4, 0, 1);
        // degenerate: zero product
        add_row(mk(0, 3, 1, 1, 1, 0, 0, 0, 0), 1, 6 << 4, 0, 0);
        // two long sides: all four terms positive, valid
        add_row(mk(0, 100, 100, 1, 1, 0, 0, 0, 0), 0, 0, 0, 0);
        add_row(mk(0, 16, 16, 16, 16, 0, 0, 0, 0), 0, 0, 0, 0);
        // unit square of 16 raw units: each edge 1.0 (256), area 1.0 (256)
        add_row(mk(1, 0, 0, 16, 0, 16, 16, 0, 16), 1, 1024, 256, 0);
        add_row(mk(1, 0, 0, 0, 16, 16, 16, 16, 0), 1, 1024, 256, 0);
        add_row(mk(1, -32768, -32768, 32767, -32768, 32767, 32767, -32768, 32767), 0, 0, 0, 0);
        add_row(mk(1, 32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768), 0, 0, 0, 0);
        add_row(mk(1, -32768, 32767, 32767, -32768, -32768, 32767, 32767, -32768), 0, 0, 0, 0);
        add_row(mk(1, 5, 7, 5, 7, 5, 7, 5, 7), 1, 0, 0, 0);
        add_row(mk(1, 3, 0, 0, 4, -3, 0, 0, -4), 0, 0, 0, 0);
        add_row(mk(0, 16383, 0, 0, 0, 1, 2, 3, 4), 0, 0, 0, 0);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (shape_table[r]) begin
            send_shape(shape_table[r].shape, 1'b0);
            if (shape_table[r].known && predict_shape(shape_table[r].shape)
                    != shape_table[r].result) begin
                report_mismatch("table row", r, r);
            end
        end
        i_valid <= 1'b0;

        // sender pauses until the pipeline has drained
        wait (shape_results.size() == 0);
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 300) long_holdoff = 1'b1;
            if (i == N_RANDOM - 200) tail_phase = 1'b1;
            s.func = 1'($urandom_range(0, 1));
            if (s.func) begin
                s.first_x = rand_coord();  s.first_y = rand_coord();
                s.second_x = rand_coord(); s.second_y = rand_coord();
                s.third_x = rand_coord();  s.third_y = rand_coord();
                s.fourth_x = rand_coord(); s.fourth_y = rand_coord();
            end else begin
                s.first_x = rand_side();  s.first_y = rand_side();
                s.second_x = rand_side(); s.second_y = rand_side();
                s.third_x = 16'($urandom);  s.third_y = 16'($urandom);
                s.fourth_x = 16'($urandom); s.fourth_y = 16'($urandom);
            end
            send_shape(s, 1'b1);
        end
        i_valid <= 1'b0;

        wait (shape_results.size() == 0);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb_quadrilateral_perimeter_area_core OK");
        end else begin
            $display("tb_quadrilateral_perimeter_area_core NOT OK");
        end
        $finish;
    end

endmodule
